// ===== rtl/core/kpr_pkg.sv =====
// kpr_pkg: shared types, codes and constants of the keypad remap and macro engine.
// Used by every module under rtl/core; depends on nothing.
`default_nettype none
package kpr_pkg;

  // Default sizes, handed to the top level parameters
  localparam int PROFILE_COUNT_DEF = 3;
  localparam int KEY_ROWS_DEF      = 4;
  localparam int KEY_COLS_DEF      = 5;
  localparam int MACRO_COUNT_DEF   = 10;
  localparam int MACRO_DEPTH_DEF   = 5;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int KEY_W      = 16;

  localparam logic [KEY_W-1:0] MACRO_BASE = 16'hF000;

  // Register reset values
  localparam logic [KEY_W-1:0] VOLUME_UP_RST   = 16'd169;
  localparam logic [KEY_W-1:0] VOLUME_DOWN_RST = 16'd170;
  localparam logic [KEY_W-1:0] BRIGHT_UP_RST   = 16'd189;
  localparam logic [KEY_W-1:0] BRIGHT_DOWN_RST = 16'd190;
  localparam logic [KEY_W-1:0] ARROW_RIGHT_RST = 16'd79;
  localparam logic [KEY_W-1:0] ARROW_LEFT_RST  = 16'd80;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_PROFILE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KNOB_MODE      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VOLUME_UP      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VOLUME_DOWN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHT_UP      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHT_DOWN    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ARROW_RIGHT    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ARROW_LEFT     = 3'd7;

  // Knob modes
  localparam logic [7:0] MODE_VOLUME = 8'd0;
  localparam logic [7:0] MODE_BRIGHT = 8'd1;
  localparam logic [7:0] MODE_ARROW  = 8'd2;

  typedef enum logic [2:0] {
    CMD_PRESS     = 3'd0,
    CMD_KNOB      = 3'd1,
    CMD_SET_KEY   = 3'd2,
    CMD_SET_LEN   = 3'd3,
    CMD_SET_MACRO = 3'd4
  } kpr_cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_KEY_WAIT,
    ST_LEN_WAIT,
    ST_EMIT
  } kpr_state_t;

  // Configuration as seen by the controller
  typedef struct packed {
    logic [1:0]       profile;
    logic             knob_ok;
    logic [KEY_W-1:0] knob_cw;
    logic [KEY_W-1:0] knob_ccw;
  } kpr_cfg_t;

  // Address width of a store of the given depth, at least one bit
  function automatic int kpr_aw(input int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/kpr_ram.sv =====
// kpr_ram: generic simple dual-port RAM, one write and one registered read port.
// Uses kpr_pkg for the address width helper.
`default_nettype none
module kpr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                             clk,
  input  wire logic                             we,
  input  wire logic [kpr_pkg::kpr_aw(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                 wdata,
  input  wire logic [kpr_pkg::kpr_aw(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]                 rdata
);
  import kpr_pkg::*;

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/core/kpr_cfg.sv =====
// kpr_cfg: configuration registers and knob keycode selection.
// Uses kpr_pkg for register indexes, reset values and kpr_cfg_t.
`default_nettype none
module kpr_cfg #(
  parameter int PROFILE_COUNT = kpr_pkg::PROFILE_COUNT_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [kpr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [kpr_pkg::CFG_DATA_W-1:0] cfg_data,
  output kpr_pkg::kpr_cfg_t                   cfg
);
  import kpr_pkg::*;

  logic [1:0]       active_profile;
  logic [7:0]       knob_mode;
  logic [KEY_W-1:0] volume_up, volume_down;
  logic [KEY_W-1:0] bright_up, bright_down;
  logic [KEY_W-1:0] arrow_right, arrow_left;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_profile <= '0;
      knob_mode      <= MODE_VOLUME;
      volume_up      <= VOLUME_UP_RST;
      volume_down    <= VOLUME_DOWN_RST;
      bright_up      <= BRIGHT_UP_RST;
      bright_down    <= BRIGHT_DOWN_RST;
      arrow_right    <= ARROW_RIGHT_RST;
      arrow_left     <= ARROW_LEFT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ACTIVE_PROFILE: begin
          // drop a profile number that has no table
          if (32'(cfg_data[1:0]) < PROFILE_COUNT) begin
            active_profile <= cfg_data[1:0];
          end
        end
        REG_KNOB_MODE:   knob_mode   <= cfg_data[7:0];
        REG_VOLUME_UP:   volume_up   <= cfg_data;
        REG_VOLUME_DOWN: volume_down <= cfg_data;
        REG_BRIGHT_UP:   bright_up   <= cfg_data;
        REG_BRIGHT_DOWN: bright_down <= cfg_data;
        REG_ARROW_RIGHT: arrow_right <= cfg_data;
        REG_ARROW_LEFT:  arrow_left  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.profile  = active_profile;
    cfg.knob_ok  = 1'b1;
    cfg.knob_cw  = volume_up;
    cfg.knob_ccw = volume_down;
    case (knob_mode)
      MODE_VOLUME: ;
      MODE_BRIGHT: begin
        cfg.knob_cw  = bright_up;
        cfg.knob_ccw = bright_down;
      end
      MODE_ARROW: begin
        cfg.knob_cw  = arrow_right;
        cfg.knob_ccw = arrow_left;
      end
      default: cfg.knob_ok = 1'b0;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/core/kpr_ctrl.sv =====
// kpr_ctrl: command sequencer; reads, writes and clears the key table and macro RAMs.
// Uses kpr_pkg for commands, states and kpr_cfg_t.
`default_nettype none
module kpr_ctrl #(
  parameter int PROFILE_COUNT = kpr_pkg::PROFILE_COUNT_DEF,
  parameter int KEY_ROWS      = kpr_pkg::KEY_ROWS_DEF,
  parameter int KEY_COLS      = kpr_pkg::KEY_COLS_DEF,
  parameter int MACRO_COUNT   = kpr_pkg::MACRO_COUNT_DEF,
  parameter int MACRO_DEPTH   = kpr_pkg::MACRO_DEPTH_DEF,
  localparam int KT_DEPTH     = PROFILE_COUNT * KEY_ROWS * KEY_COLS,
  localparam int MS_DEPTH     = MACRO_COUNT * (MACRO_DEPTH + 1),
  localparam int KT_AW        = kpr_pkg::kpr_aw(KT_DEPTH),
  localparam int MS_AW        = kpr_pkg::kpr_aw(MS_DEPTH)
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [2:0]                cmd,
  input  wire logic [7:0]                row,
  input  wire logic [7:0]                col,
  input  wire logic                      clockwise,
  input  wire logic [7:0]                macro_id,
  input  wire logic [7:0]                slot,
  input  wire logic [7:0]                length,
  input  wire logic [kpr_pkg::KEY_W-1:0] keycode_in,
  input  wire kpr_pkg::kpr_cfg_t         cfg,
  output logic                           kt_we,
  output logic [KT_AW-1:0]               kt_waddr,
  output logic [kpr_pkg::KEY_W-1:0]      kt_wdata,
  output logic [KT_AW-1:0]               kt_raddr,
  input  wire logic [kpr_pkg::KEY_W-1:0] kt_rdata,
  output logic                           ms_we,
  output logic [MS_AW-1:0]               ms_waddr,
  output logic [kpr_pkg::KEY_W-1:0]      ms_wdata,
  output logic [MS_AW-1:0]               ms_raddr,
  input  wire logic [kpr_pkg::KEY_W-1:0] ms_rdata,
  output logic                           strobe,
  output logic [kpr_pkg::KEY_W-1:0]      keycode,
  output logic                           last
);
  import kpr_pkg::*;

  localparam int CLR_DEPTH = (KT_DEPTH > MS_DEPTH) ? KT_DEPTH : MS_DEPTH;
  localparam int CLR_W     = kpr_aw(CLR_DEPTH);
  localparam int ID_W      = kpr_aw(MACRO_COUNT);
  localparam int LEN_W     = kpr_aw(MACRO_DEPTH + 1);
  localparam int SLOT_W    = kpr_aw(MACRO_DEPTH);

  kpr_state_t       state, state_next;
  logic [CLR_W-1:0] clr, clr_next;

  // captured command word
  kpr_cmd_t         cmd_q;
  logic [7:0]       row_q, col_q, mid_q, slot_q, len_in_q;
  logic             cw_q;
  logic [KEY_W-1:0] kin_q;

  // macro playback
  logic [ID_W-1:0]   id_q, id_next;
  logic [LEN_W-1:0]  n_q, n_next;
  logic [SLOT_W-1:0] idx_q, idx_next;

  logic             strobe_next, last_next;
  logic [KEY_W-1:0] keycode_next;

  logic             pos_ok, accept, run_last;
  logic [KEY_W-1:0] macro_ofs;

  // entry 0 of each macro row holds its length, entries 1.. its keys
  function automatic logic [MS_AW-1:0] ms_addr(input int id, input int pos);
    return MS_AW'(id * (MACRO_DEPTH + 1) + pos);
  endfunction

  assign accept    = start && (state == ST_IDLE);
  assign busy      = (state != ST_IDLE);
  assign pos_ok    = (32'(row_q) < KEY_ROWS) && (32'(col_q) < KEY_COLS);
  assign macro_ofs = 16'(kt_rdata - MACRO_BASE);
  assign run_last  = (LEN_W'(idx_q) + LEN_W'(1)) == n_q;

  assign kt_raddr = KT_AW'((32'(cfg.profile) * KEY_ROWS + 32'(row_q)) * KEY_COLS
                           + 32'(col_q));

  always_comb begin
    state_next   = state;
    clr_next     = clr;
    id_next      = id_q;
    n_next       = n_q;
    idx_next     = idx_q;
    strobe_next  = 1'b0;
    last_next    = 1'b0;
    keycode_next = keycode;
    kt_we        = 1'b0;
    kt_waddr     = kt_raddr;
    kt_wdata     = kin_q;
    ms_we        = 1'b0;
    ms_waddr     = ms_addr(32'(mid_q), 32'(slot_q) + 1);
    ms_wdata     = kin_q;
    ms_raddr     = ms_addr(32'(id_q), 0);

    unique case (state)
      ST_CLEAR: begin
        // zero both stores, one entry a cycle
        kt_we    = 32'(clr) < KT_DEPTH;
        kt_waddr = KT_AW'(clr);
        kt_wdata = '0;
        ms_we    = 32'(clr) < MS_DEPTH;
        ms_waddr = MS_AW'(clr);
        ms_wdata = '0;
        clr_next = clr + CLR_W'(1);
        if (clr == CLR_W'(CLR_DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_next = ST_IDLE;
        case (cmd_q)
          CMD_PRESS: begin
            if (pos_ok) begin
              state_next = ST_KEY_WAIT;
            end
          end
          CMD_KNOB: begin
            strobe_next  = cfg.knob_ok;
            last_next    = 1'b1;
            keycode_next = cw_q ? cfg.knob_cw : cfg.knob_ccw;
          end
          CMD_SET_KEY: kt_we = pos_ok;
          CMD_SET_LEN: begin
            ms_we    = (32'(mid_q) < MACRO_COUNT) && (32'(len_in_q) <= MACRO_DEPTH);
            ms_waddr = ms_addr(32'(mid_q), 0);
            ms_wdata = KEY_W'(len_in_q);
          end
          CMD_SET_MACRO: begin
            ms_we = (32'(mid_q) < MACRO_COUNT) && (32'(slot_q) < MACRO_DEPTH);
          end
          default: ;
        endcase
      end
      ST_KEY_WAIT: begin
        state_next = ST_IDLE;
        id_next    = ID_W'(macro_ofs);
        if (kt_rdata < MACRO_BASE) begin
          strobe_next  = 1'b1;
          last_next    = 1'b1;
          keycode_next = kt_rdata;
        end else if (32'(macro_ofs) < MACRO_COUNT) begin
          ms_raddr   = ms_addr(32'(macro_ofs), 0);
          state_next = ST_LEN_WAIT;
        end
      end
      ST_LEN_WAIT: begin
        n_next   = ms_rdata[LEN_W-1:0];
        idx_next = '0;
        ms_raddr = ms_addr(32'(id_q), 1);
        // an empty macro sends nothing
        state_next = (ms_rdata[LEN_W-1:0] == '0) ? ST_IDLE : ST_EMIT;
      end
      ST_EMIT: begin
        strobe_next  = 1'b1;
        last_next    = run_last;
        keycode_next = ms_rdata;
        idx_next     = idx_q + SLOT_W'(1);
        ms_raddr     = ms_addr(32'(id_q), 32'(idx_q) + 2);
        if (run_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_CLEAR;
      clr    <= '0;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      clr    <= clr_next;
      strobe <= strobe_next;
    end
  end

  always_ff @(posedge clk) begin
    keycode <= keycode_next;
    last    <= last_next;
    id_q    <= id_next;
    n_q     <= n_next;
    idx_q   <= idx_next;
    if (accept) begin
      cmd_q    <= kpr_cmd_t'(cmd);
      row_q    <= row;
      col_q    <= col;
      cw_q     <= clockwise;
      mid_q    <= macro_id;
      slot_q   <= slot;
      len_in_q <= length;
      kin_q    <= keycode_in;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/keypad_remap_macro_engine_top.sv =====
// keypad_remap_macro_engine_top: key remap and macro engine, top level.
// Depends on kpr_pkg, kpr_cfg, kpr_ctrl and kpr_ram.
//
// Usage:
//   Commands enter on start when busy is low; all fields are sampled at that
//   edge. Each result word appears on keycode/last for one cycle with strobe
//   high; last marks the final word of a command's run. The receiver cannot
//   stall the block, so results are never held back.
//   Configuration: cfg_we writes cfg_data into register cfg_index at once;
//   write only while no command is in progress.
// Command sequence (from the accept edge):
//   knob turn: busy in EXEC only, then a strobe if the knob mode is valid.
//   key press, plain code: busy in EXEC and KEY_WAIT, then the result strobes.
//   key press, macro of n keys: busy in EXEC, KEY_WAIT, LEN_WAIT and one
//   EMIT per key; the words strobe on consecutive cycles, one key word per
//   registered read of the macro RAM.
//   write commands: busy in EXEC only, no result.
// Reset: registers take their reset values, then a clearing pass zeroes the
//   key table and macro RAMs, one entry a cycle, over max(key table, macro
//   store) entries (60 with default sizes); busy stays high meanwhile.
`default_nettype none
module keypad_remap_macro_engine_top #(
  parameter int PROFILE_COUNT = kpr_pkg::PROFILE_COUNT_DEF,
  parameter int KEY_ROWS      = kpr_pkg::KEY_ROWS_DEF,
  parameter int KEY_COLS      = kpr_pkg::KEY_COLS_DEF,
  parameter int MACRO_COUNT   = kpr_pkg::MACRO_COUNT_DEF,
  parameter int MACRO_DEPTH   = kpr_pkg::MACRO_DEPTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [2:0]                     cmd,
  input  wire logic [7:0]                     row,
  input  wire logic [7:0]                     col,
  input  wire logic                           clockwise,
  input  wire logic [7:0]                     macro_id,
  input  wire logic [7:0]                     slot,
  input  wire logic [7:0]                     length,
  input  wire logic [kpr_pkg::KEY_W-1:0]      keycode_in,
  output logic                                strobe,
  output logic [kpr_pkg::KEY_W-1:0]           keycode,
  output logic                                last,
  input  wire logic                           cfg_we,
  input  wire logic [kpr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [kpr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import kpr_pkg::*;

  localparam int KT_DEPTH = PROFILE_COUNT * KEY_ROWS * KEY_COLS;
  localparam int MS_DEPTH = MACRO_COUNT * (MACRO_DEPTH + 1);
  localparam int KT_AW    = kpr_aw(KT_DEPTH);
  localparam int MS_AW    = kpr_aw(MS_DEPTH);

  kpr_cfg_t         cfg;
  logic             kt_we, ms_we;
  logic [KT_AW-1:0] kt_waddr, kt_raddr;
  logic [MS_AW-1:0] ms_waddr, ms_raddr;
  logic [KEY_W-1:0] kt_wdata, kt_rdata, ms_wdata, ms_rdata;

  kpr_cfg #(
    .PROFILE_COUNT(PROFILE_COUNT)
  ) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  kpr_ctrl #(
    .PROFILE_COUNT(PROFILE_COUNT),
    .KEY_ROWS     (KEY_ROWS),
    .KEY_COLS     (KEY_COLS),
    .MACRO_COUNT  (MACRO_COUNT),
    .MACRO_DEPTH  (MACRO_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .row       (row),
    .col       (col),
    .clockwise (clockwise),
    .macro_id  (macro_id),
    .slot      (slot),
    .length    (length),
    .keycode_in(keycode_in),
    .cfg       (cfg),
    .kt_we     (kt_we),
    .kt_waddr  (kt_waddr),
    .kt_wdata  (kt_wdata),
    .kt_raddr  (kt_raddr),
    .kt_rdata  (kt_rdata),
    .ms_we     (ms_we),
    .ms_waddr  (ms_waddr),
    .ms_wdata  (ms_wdata),
    .ms_raddr  (ms_raddr),
    .ms_rdata  (ms_rdata),
    .strobe    (strobe),
    .keycode   (keycode),
    .last      (last)
  );

  kpr_ram #(
    .WIDTH(KEY_W),
    .DEPTH(KT_DEPTH)
  ) u_key_table (
    .clk  (clk),
    .we   (kt_we),
    .waddr(kt_waddr),
    .wdata(kt_wdata),
    .raddr(kt_raddr),
    .rdata(kt_rdata)
  );

  kpr_ram #(
    .WIDTH(KEY_W),
    .DEPTH(MS_DEPTH)
  ) u_macro_store (
    .clk  (clk),
    .we   (ms_we),
    .waddr(ms_waddr),
    .wdata(ms_wdata),
    .raddr(ms_raddr),
    .rdata(ms_rdata)
  );

  // a macro run has no gaps between its words
  a_run_contiguous: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |=> strobe)
    else $error("macro run broke before its last word");

  // an accepted command raises busy in the cycle after, holding off the next one
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy not raised after accepting a command");

  // every result word comes out of work in progress
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(busy))
    else $error("result word without a command in progress");

endmodule
`default_nettype wire
